// ===== hw/rtl/cipc_pkg.sv =====
package cipc_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int TABLE_DEPTH_DEF = 128;

   localparam int SLOPE_W  = 20;
   localparam int OFFSET_W = 24;
   localparam int NOTE_W   = 23;
   localparam int FRAC_W   = 16;
   localparam int FREQ_W   = 32;
   localparam int INDEX_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [NOTE_W-1:0]   NOTE_MAX     = NOTE_W'(127 << FRAC_W);
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(6554);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(524288);

   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_SLOPE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_OFFSET = CSR_IDX_W'(1);

   localparam logic ACTION_SCAN        = 1'b0;
   localparam logic ACTION_TABLE_WRITE = 1'b1;

   typedef struct packed {
      logic ready;       // snapshot stage can take a new result
      logic table_busy;  // a result has not yet read the table
   } cipc_status_type;

endpackage

// ===== hw/rtl/cipc_ram.sv =====
module cipc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/cipc_lane.sv =====
module cipc_lane
   import cipc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   scan_en,
   input  logic                   last,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS+1:0] total
);

   localparam int SUM_W = SAMPLE_BITS + 2;

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   // running sum including the sample of this scan
   assign total = sum_ff + SUM_W'(sample);

   always_comb begin
      sum_in = sum_ff;
      if (scan_en) begin
         sum_in = last ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== hw/rtl/cipc_merge.sv =====
module cipc_merge
   import cipc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [3:0][SAMPLE_BITS+1:0]      sums,
   input  logic [SLOPE_W-1:0]               note_slope,
   input  logic signed [OFFSET_W-1:0]       note_offset,
   input  logic                             tbl_we,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   tbl_addr,
   input  logic [FREQ_W-1:0]                tbl_data,
   output cipc_status_type                  status,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [SAMPLE_BITS-1:0]           rsp_gate_level,
   output logic [SAMPLE_BITS-1:0]           rsp_pitch_code,
   output logic [NOTE_W-1:0]                rsp_note_position,
   output logic signed [SAMPLE_BITS+1:0]    rsp_level_one,
   output logic signed [SAMPLE_BITS+1:0]    rsp_level_two,
   output logic signed [SAMPLE_BITS+1:0]    rsp_level_three,
   output logic signed [SAMPLE_BITS+1:0]    rsp_level_four,
   output logic [FREQ_W-1:0]                rsp_note_frequency
);

   localparam int SW     = SAMPLE_BITS + 2;
   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int TOP    = TABLE_DEPTH - 1;
   localparam int PROD_W = SAMPLE_BITS + SLOPE_W;
   localparam int NSUM_W = PROD_W + 2;
   localparam int DIFF_W = FREQ_W + 1;
   localparam int IP_W   = 9;
   localparam int MUL_W  = DIFF_W + FRAC_W + 1;

   typedef struct packed {
      logic [3:0][SW-1:0] sums;
      logic [NOTE_W-1:0]  note;
   } carry_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, out_v_in;
   logic free1, free2, free3, free4, free5, free_out;

   carry_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, co_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W-1:0]       prod_in;
   logic signed [NSUM_W-1:0] note_sum;
   logic [NOTE_W-1:0]       note_sat;
   logic [IP_W-1:0]         ip_ext;
   logic [IP_W-1:0]         ip_next;
   logic                    top_sel;
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;
   logic                    rd_en;
   logic [FREQ_W-1:0]       rd_data_a;
   logic [FREQ_W-1:0]       rd_data_b;
   logic                    top4_ff;
   logic                    top5_ff;
   logic [FREQ_W-1:0]       lo5_ff;
   logic signed [MUL_W-1:0] mul_ff;
   logic signed [MUL_W-1:0] mul_in;
   logic [DIFF_W-1:0]       diff;
   logic signed [MUL_W-1:0] mul_shift;
   logic [FREQ_W-1:0]       freq_in;
   logic [FREQ_W-1:0]       freq_ff;

   // stage handshake: a stage frees up when it is empty or its successor takes it
   assign free_out = !out_v_ff || !rsp_stall;
   assign free5    = !v5_ff || free_out;
   assign free4    = !v4_ff || free5;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;

   assign status.ready      = free1;
   assign status.table_busy = v1_ff || v2_ff || v3_ff;

   assign v1_in    = load ? 1'b1 : (v1_ff && !free2);
   assign v2_in    = (v1_ff && free2) ? 1'b1 : (v2_ff && !free3);
   assign v3_in    = (v2_ff && free3) ? 1'b1 : (v3_ff && !free4);
   assign v4_in    = (v3_ff && free4) ? 1'b1 : (v4_ff && !free5);
   assign v5_in    = (v4_ff && free5) ? 1'b1 : (v5_ff && !free_out);
   assign out_v_in = (v5_ff && free_out) ? 1'b1 : (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
         v5_ff    <= v5_in;
         out_v_ff <= out_v_in;
      end
   end

   // pitch code times slope
   assign prod_in = PROD_W'(c1_ff.sums[1][SW-1:2]) * note_slope;

   // offset and clamp to 0 .. 127.0
   assign note_sum = $signed({2'b00, prod_ff}) + NSUM_W'(note_offset);

   always_comb begin
      if (note_sum[NSUM_W-1]) begin
         note_sat = '0;
      end else if (note_sum > $signed(NSUM_W'(NOTE_MAX))) begin
         note_sat = NOTE_MAX;
      end else begin
         note_sat = note_sum[NOTE_W-1:0];
      end
   end

   // table addresses from the integer part; at or past the top only the top entry counts
   assign ip_ext    = IP_W'(c3_ff.note[NOTE_W-1:FRAC_W]);
   assign ip_next   = ip_ext + IP_W'(1);
   assign top_sel   = ip_ext >= IP_W'(TOP);
   assign rd_addr_a = top_sel ? AW'(TOP) : ip_ext[AW-1:0];
   assign rd_addr_b = top_sel ? AW'(TOP) : ip_next[AW-1:0];
   assign rd_en     = v3_ff && free4;

   cipc_ram #(
      .WIDTH (FREQ_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_addr),
      .wr_data   (tbl_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // lo*(1-f) + hi*f == lo + (hi-lo)*f, exact after the floor shift
   assign diff   = {1'b0, rd_data_b} - {1'b0, rd_data_a};
   assign mul_in = $signed(diff) * $signed({1'b0, c4_ff.note[FRAC_W-1:0]});

   assign mul_shift = mul_ff >>> FRAC_W;
   assign freq_in   = top5_ff ? lo5_ff : (lo5_ff + mul_shift[FREQ_W-1:0]);

   always_ff @(posedge clock) begin
      if (load) begin
         c1_ff.sums <= sums;
         c1_ff.note <= '0;
      end
      if (v1_ff && free2) begin
         c2_ff   <= c1_ff;
         prod_ff <= prod_in;
      end
      if (v2_ff && free3) begin
         c3_ff.sums <= c2_ff.sums;
         c3_ff.note <= note_sat;
      end
      if (rd_en) begin
         c4_ff   <= c3_ff;
         top4_ff <= top_sel;
      end
      if (v4_ff && free5) begin
         c5_ff   <= c4_ff;
         top5_ff <= top4_ff;
         lo5_ff  <= rd_data_a;
         mul_ff  <= mul_in;
      end
      if (v5_ff && free_out) begin
         co_ff   <= c5_ff;
         freq_ff <= freq_in;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_gate_level     = co_ff.sums[0][SW-1:2];
   assign rsp_pitch_code     = co_ff.sums[1][SW-1:2];
   assign rsp_note_position  = co_ff.note;
   // sum minus midscale is the sum with its top bit inverted
   assign rsp_level_one      = {~co_ff.sums[0][SW-1], co_ff.sums[0][SW-2:0]};
   assign rsp_level_two      = {~co_ff.sums[1][SW-1], co_ff.sums[1][SW-2:0]};
   assign rsp_level_three    = {~co_ff.sums[2][SW-1], co_ff.sums[2][SW-2:0]};
   assign rsp_level_four     = {~co_ff.sums[3][SW-1], co_ff.sums[3][SW-2:0]};
   assign rsp_note_frequency = freq_ff;

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> !(v1_ff || v2_ff || v3_ff))
      else $error("table written while a pending result has not read it");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free1)
      else $error("result snapshot taken while the snapshot stage is full");

   a_table_data_held: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !free5) |=> $stable(rd_data_a) && $stable(rd_data_b))
      else $error("table read data changed under a stalled stage");

   a_note_clamped: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (co_ff.note <= NOTE_MAX))
      else $error("note position above the clamp");

endmodule

// ===== hw/rtl/cv_input_pitch_converter_top.sv =====
// Control-voltage pitch converter. One scan (four converter samples) or one
// frequency table write is taken per clock when not stalled. Every fourth scan
// yields one result transaction: averaged gate and pitch codes, four bipolar
// levels, the note position (pitch code * slope + offset, clamped to 0..127 in
// Q7.16) and a frequency interpolated between two adjacent table entries. Four
// accumulator lanes sum the channels; a six-stage merge pipeline (snapshot,
// slope multiply, offset and clamp, dual-port table read, interpolation
// multiply, output register) presents the result. A table write is held off
// while a result sits in the first three merge stages, which a stalled result
// side can prolong, and a fourth scan is held off only when a stalled result
// side has filled the merge pipeline. Load the table before sending scans;
// results that read unwritten entries are undefined.
module cv_input_pitch_converter_top
   import cipc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [SAMPLE_BITS-1:0]        req_sample_gate,
   input  logic [SAMPLE_BITS-1:0]        req_sample_pitch,
   input  logic [SAMPLE_BITS-1:0]        req_sample_third,
   input  logic [SAMPLE_BITS-1:0]        req_sample_fourth,
   input  logic [INDEX_W-1:0]            req_table_index,
   input  logic [FREQ_W-1:0]             req_table_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SAMPLE_BITS-1:0]        rsp_gate_level,
   output logic [SAMPLE_BITS-1:0]        rsp_pitch_code,
   output logic [NOTE_W-1:0]             rsp_note_position,
   output logic signed [SAMPLE_BITS+1:0] rsp_level_one,
   output logic signed [SAMPLE_BITS+1:0] rsp_level_two,
   output logic signed [SAMPLE_BITS+1:0] rsp_level_three,
   output logic signed [SAMPLE_BITS+1:0] rsp_level_four,
   output logic [FREQ_W-1:0]             rsp_note_frequency
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int IX_W = 9;

   logic [SLOPE_W-1:0]         slope_ff;
   logic [SLOPE_W-1:0]         slope_in;
   logic [OFFSET_W-1:0]        offset_ff;
   logic [OFFSET_W-1:0]        offset_in;
   logic [1:0]                 count_ff;
   logic [1:0]                 count_in;
   logic                       accept;
   logic                       scan_en;
   logic                       last;
   logic                       tbl_we;
   logic [IX_W-1:0]            idx_ext;
   logic [3:0][SAMPLE_BITS-1:0] samples;
   logic [3:0][SAMPLE_BITS+1:0] totals;
   cipc_status_type            status;

   always_comb begin
      slope_in  = slope_ff;
      offset_in = offset_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NOTE_SLOPE:  slope_in  = csr_data[SLOPE_W-1:0];
            CSR_NOTE_OFFSET: offset_in = csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff  <= SLOPE_RESET;
         offset_ff <= OFFSET_RESET;
         count_ff  <= '0;
      end else begin
         slope_ff  <= slope_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   assign last = (count_ff == 2'd3);

   // table writes wait until any pending result has read the table
   assign req_stall = (req_action == ACTION_TABLE_WRITE) ? status.table_busy
                                                        : (last && !status.ready);

   assign accept   = req_valid && !req_stall;
   assign scan_en  = accept && (req_action == ACTION_SCAN);
   assign count_in = scan_en ? count_ff + 2'd1 : count_ff;

   assign idx_ext = IX_W'(req_table_index);
   assign tbl_we  = accept && (req_action == ACTION_TABLE_WRITE)
                    && (idx_ext < IX_W'(TABLE_DEPTH));

   assign samples[0] = req_sample_gate;
   assign samples[1] = req_sample_pitch;
   assign samples[2] = req_sample_third;
   assign samples[3] = req_sample_fourth;

   for (genvar g = 0; g < 4; g++) begin : g_lane
      cipc_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .scan_en (scan_en),
         .last    (last),
         .sample  (samples[g]),
         .total   (totals[g])
      );
   end

   cipc_merge #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_merge (
      .clock              (clock),
      .reset              (reset),
      .load               (scan_en && last),
      .sums               (totals),
      .note_slope         (slope_ff),
      .note_offset        ($signed(offset_ff)),
      .tbl_we             (tbl_we),
      .tbl_addr           (idx_ext[AW-1:0]),
      .tbl_data           (req_table_value),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_gate_level     (rsp_gate_level),
      .rsp_pitch_code     (rsp_pitch_code),
      .rsp_note_position  (rsp_note_position),
      .rsp_level_one      (rsp_level_one),
      .rsp_level_two      (rsp_level_two),
      .rsp_level_three    (rsp_level_three),
      .rsp_level_four     (rsp_level_four),
      .rsp_note_frequency (rsp_note_frequency)
   );

endmodule
